@@ rtl/salc_pkg.sv @@
`default_nettype none

package salc_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_BITS_DEF    = 48;

  // Fixed field widths.
  localparam int ADDR_W  = 48;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int SETB_W  = 3;
  localparam int BLKB_W  = 5;
  localparam int WAYSR_W = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register reset values.
  localparam logic [SETB_W-1:0]  SET_BITS_RST   = 3'd1;
  localparam logic [BLKB_W-1:0]  BLOCK_BITS_RST = 5'd4;
  localparam logic [WAYSR_W-1:0] WAYS_RST       = 4'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  // Access kinds ('L', 'S', 'M'); any other code behaves as a load.
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  // Saturating counter increment by zero, one or two.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [1:0] inc);
    logic [CNT_W+1:0] sum;
    sum = {2'b00, v} + {{CNT_W{1'b0}}, inc};
    sat_add = (sum > {2'b00, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/set_assoc_lru_cache_sim_core.sv @@
`default_nettype none

// Set-associative cache model with LRU replacement and saturating hit, miss and
// eviction counters. The accepting cycle of an access reads the addressed set's
// row (all tags plus a count of valid lines) from a single-port tag memory, and
// the lookup state that follows compares all ways in parallel, reorders the row
// and writes it back while loading the result register. The lookup cycle waits
// while the result register holds a result that is neither free nor being
// drained, and a new access is taken only after the lookup is done, as the
// read-modify-write of the tag memory must finish first. An access may be
// taken while an earlier result still waits. After reset the block is ready
// at once: one valid flag per set, cleared by reset, marks rows that have
// never been written as empty.
module set_assoc_lru_cache_sim_core #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS    = salc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [salc_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [salc_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [salc_pkg::ADDR_W-1:0]     in_address,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_outcome,
  output logic                                 out_extra_hit,
  output logic [salc_pkg::CNT_W-1:0]           out_hit_total,
  output logic [salc_pkg::CNT_W-1:0]           out_miss_total,
  output logic [salc_pkg::CNT_W-1:0]           out_eviction_total
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int TAG_W    = (ADDR_BITS < salc_pkg::ADDR_W) ? ADDR_BITS : salc_pkg::ADDR_W;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SH_W     = 6;

  typedef struct packed {
    logic [WCNT_W-1:0]                  cnt;
    logic [MAX_WAYS-1:0][TAG_W-1:0]     tags;
  } row_t;

  // Configuration registers.
  logic [salc_pkg::SETB_W-1:0]  set_bits_r;
  logic [salc_pkg::BLKB_W-1:0]  block_bits_r;
  logic [salc_pkg::WAYSR_W-1:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= salc_pkg::SET_BITS_RST;
      block_bits_r <= salc_pkg::BLOCK_BITS_RST;
      ways_r       <= salc_pkg::WAYS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        salc_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_wdata[salc_pkg::SETB_W-1:0];
        salc_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_wdata;
        salc_pkg::CFG_WAYS:       ways_r       <= cfg_wdata[salc_pkg::WAYSR_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split.
  logic [3:0]              sb_eff;
  logic [SH_W-1:0]         tag_shift;
  logic [TAG_W-1:0]        addr_lo;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] set_idx;
  logic [TAG_W-1:0]        tag_in;

  always_comb begin
    sb_eff    = (int'(set_bits_r) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_r};
    tag_shift = SH_W'(block_bits_r) + SH_W'(sb_eff);
    addr_lo   = in_address[TAG_W-1:0];
    set_mask  = ~({MAX_SET_BITS{1'b1}} << sb_eff);
    set_idx   = MAX_SET_BITS'(addr_lo >> block_bits_r) & set_mask;
    tag_in    = addr_lo >> tag_shift;
  end

  // Control and request registers.
  salc_pkg::state_t        state_r, state_nxt;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [TAG_W-1:0]        tag_r;
  logic                    modify_r;
  logic                    in_fire;
  logic                    advance;

  assign in_ready = (state_r == salc_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign advance  = (state_r == salc_pkg::S_LOOK) && (!out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      salc_pkg::S_IDLE: if (in_fire) state_nxt = salc_pkg::S_LOOK;
      salc_pkg::S_LOOK: if (advance) state_nxt = salc_pkg::S_IDLE;
      default:          state_nxt = salc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= salc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      set_r    <= set_idx;
      tag_r    <= tag_in;
      modify_r <= (in_kind == salc_pkg::KIND_MODIFY);
    end
  end

  // Tag memory: one row per set, read in the accepting cycle and written back
  // in the lookup cycle. A read and a write never fall in the same cycle.
  row_t                tag_mem [NUM_SETS];
  row_t                rd_row_r;
  row_t                row_nxt;
  logic [NUM_SETS-1:0] row_vld_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_row_r <= tag_mem[set_idx];
    end
    if (advance) begin
      tag_mem[set_r] <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_vld_r <= row_vld_r[set_idx];
      end
      if (advance) begin
        row_vld_r[set_r] <= 1'b1;
      end
    end
  end

  // Lookup. Valid lines of a set always form a prefix, so a count stands for
  // the valid bits of the row.
  logic [WCNT_W-1:0]   nw;
  logic [WCNT_W-1:0]   cur_cnt;
  logic [WCNT_W-1:0]   lim;
  logic [WCNT_W-1:0]   last;
  logic [MAX_WAYS-1:0] match;
  logic                hit_found;
  logic [WAY_W-1:0]    hit_way;
  salc_pkg::outcome_t  outcome;

  always_comb begin
    if (ways_r == '0) begin
      nw = WCNT_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      nw = WCNT_W'(MAX_WAYS);
    end else begin
      nw = WCNT_W'(ways_r);
    end
    cur_cnt = rd_vld_r ? rd_row_r.cnt : '0;
    lim     = (cur_cnt < nw) ? cur_cnt : nw;
    last    = lim - WCNT_W'(1);
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = (WCNT_W'(w) < lim) && (rd_row_r.tags[w] == tag_r);
    end
    hit_found = |match;
    hit_way   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
    end
    if (hit_found) begin
      outcome = salc_pkg::OUT_HIT;
    end else if (cur_cnt < nw) begin
      outcome = salc_pkg::OUT_FILL;
    end else begin
      outcome = salc_pkg::OUT_EVICT;
    end
  end

  // Row update.
  always_comb begin
    row_nxt     = rd_row_r;
    row_nxt.cnt = cur_cnt;
    case (outcome)
      salc_pkg::OUT_HIT: begin
        // The hit line moves to the end of the valid lines in use.
        for (int p = 0; p < MAX_WAYS - 1; p++) begin
          if (WCNT_W'(p) >= WCNT_W'(hit_way) && WCNT_W'(p) < last) begin
            row_nxt.tags[p] = rd_row_r.tags[p+1];
          end
        end
        row_nxt.tags[last[WAY_W-1:0]] = rd_row_r.tags[hit_way];
      end
      salc_pkg::OUT_FILL: begin
        row_nxt.tags[cur_cnt[WAY_W-1:0]] = tag_r;
        row_nxt.cnt = cur_cnt + WCNT_W'(1);
      end
      salc_pkg::OUT_EVICT: begin
        for (int p = 0; p < MAX_WAYS - 1; p++) begin
          if (WCNT_W'(p + 1) < nw) begin
            row_nxt.tags[p] = rd_row_r.tags[p+1];
          end
        end
        row_nxt.tags[last[WAY_W-1:0]] = tag_r;
      end
      default: ;
    endcase
  end

  // Counters and result register.
  logic [salc_pkg::CNT_W-1:0] hit_r, miss_r, evict_r;
  logic [salc_pkg::CNT_W-1:0] hit_nxt, miss_nxt, evict_nxt;
  logic [1:0]                 hit_inc;
  logic                       out_valid_r;

  always_comb begin
    hit_inc   = {1'b0, (outcome == salc_pkg::OUT_HIT)} + {1'b0, modify_r};
    hit_nxt   = salc_pkg::sat_add(hit_r, hit_inc);
    miss_nxt  = salc_pkg::sat_add(miss_r, {1'b0, (outcome != salc_pkg::OUT_HIT)});
    evict_nxt = salc_pkg::sat_add(evict_r, {1'b0, (outcome == salc_pkg::OUT_EVICT)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= '0;
      miss_r      <= '0;
      evict_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        hit_r       <= hit_nxt;
        miss_r      <= miss_nxt;
        evict_r     <= evict_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_outcome        <= outcome;
      out_extra_hit      <= modify_r;
      out_hit_total      <= hit_nxt;
      out_miss_total     <= miss_nxt;
      out_eviction_total <= evict_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
